FILE: rtl/fosf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fosf_pkg
// Shared widths, codes, command type and arithmetic helpers for the
// first-order shelving filter.
// ----------------------------------------------------------------------------
package fosf_pkg;

	localparam int SAMPLE_W  = 24;
	localparam int CHANNELS  = 2;
	localparam int STATE_W   = SAMPLE_W + 2;
	localparam int COEF_W    = 24;
	localparam int COEF_FRAC = 23;
	localparam int GAIN_FRAC = 20;

	// multiplier B operand carries x +/- y1, the widest of its three uses
	localparam int MOPB_W    = STATE_W + 1;
	localparam int PROD_W    = COEF_W + MOPB_W;
	localparam int RND_A_W   = PROD_W - COEF_FRAC;
	localparam int ACC_W     = RND_A_W + 1;
	localparam int RND_G_W   = PROD_W - GAIN_FRAC;
	localparam int OUT_ACC_W = RND_G_W + 1;

	// configuration register indexes
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_COEF_A     = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_HALF_GAIN  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_SHELF_TYPE = 2'd2;

	// multiplier operand selection
	localparam logic [1:0] MSEL_W  = 2'd0;
	localparam logic [1:0] MSEL_XH = 2'd1;
	localparam logic [1:0] MSEL_S  = 2'd2;

	typedef struct packed {
		logic       accept;
		logic       mul_en;
		logic [1:0] mul_sel;
		logic       load_xh;
		logic       load_y1;
		logic       load_out;
	} cmd_t;

	function automatic logic signed [STATE_W-1:0] sat_state(
		input logic signed [ACC_W-1:0] v);
		if (&v[ACC_W-1:STATE_W-1] || ~|v[ACC_W-1:STATE_W-1])
			return v[STATE_W-1:0];
		else if (v[ACC_W-1])
			return {1'b1, {(STATE_W-1){1'b0}}};
		else
			return {1'b0, {(STATE_W-1){1'b1}}};
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] sat_sample(
		input logic signed [OUT_ACC_W-1:0] v);
		if (&v[OUT_ACC_W-1:SAMPLE_W-1] || ~|v[OUT_ACC_W-1:SAMPLE_W-1])
			return v[SAMPLE_W-1:0];
		else if (v[OUT_ACC_W-1])
			return {1'b1, {(SAMPLE_W-1){1'b0}}};
		else
			return {1'b0, {(SAMPLE_W-1){1'b1}}};
	endfunction

endpackage

FILE: rtl/fosf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fosf_ctrl
// Sequencer: steps one word through the shared multiplier and owns the
// input and output handshakes.
// ----------------------------------------------------------------------------
module fosf_ctrl
	import fosf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	output cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_XH   = 3'd1;
	localparam logic [2:0] S_P2   = 3'd2;
	localparam logic [2:0] S_Y1   = 3'd3;
	localparam logic [2:0] S_P3   = 3'd4;
	localparam logic [2:0] S_YO   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_full;

	assign out_full  = out_valid_q && out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.accept  = in_valid;
				cmd.mul_en  = in_valid;
				cmd.mul_sel = MSEL_W;
				if (in_valid)
					state_d = S_XH;
			end
			S_XH: begin
				cmd.load_xh = 1'b1;
				state_d     = S_P2;
			end
			S_P2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MSEL_XH;
				state_d     = S_Y1;
			end
			S_Y1: begin
				cmd.load_y1 = 1'b1;
				state_d     = S_P3;
			end
			S_P3: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MSEL_S;
				state_d     = S_YO;
			end
			S_YO: begin
				// hold until the output register is free
				cmd.load_out = !out_full;
				if (!out_full)
					state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_XH))
		else $error("accepted word did not start the sequence");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("stalled output word dropped");

	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.load_xh, cmd.load_y1, cmd.load_out}))
		else $error("more than one load step in a cycle");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == S_YO))
		else $error("output valid raised outside the output step");

endmodule

FILE: rtl/fosf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fosf_datapath
// Configuration registers, per-channel allpass state, shared multiplier,
// rounding and saturation, and the output register.
// ----------------------------------------------------------------------------
module fosf_datapath
	import fosf_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  cmd_t                       cmd,
	input  logic                       wr_en,
	input  logic [REG_IDX_W-1:0]       wr_index,
	input  logic [COEF_W-1:0]          wr_data,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	input  logic                       channel_in,
	output logic signed [SAMPLE_W-1:0] sample_out,
	output logic                       channel_out
);

	localparam logic signed [PROD_W-1:0] HALF_A = PROD_W'(1) << (COEF_FRAC - 1);
	localparam logic signed [PROD_W-1:0] HALF_G = PROD_W'(1) << (GAIN_FRAC - 1);

	logic signed [COEF_W-1:0]   coef_a_q;
	logic signed [COEF_W-1:0]   half_gain_q;
	logic                       shelf_type_q;
	logic signed [STATE_W-1:0]  chan_state_q [CHANNELS];

	logic signed [SAMPLE_W-1:0] x_q;
	logic                       ch_q;
	logic signed [STATE_W-1:0]  w_q;
	logic signed [STATE_W-1:0]  xh_q;
	logic signed [STATE_W-1:0]  y1_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [SAMPLE_W-1:0] sample_out_q;
	logic                       channel_out_q;

	logic signed [COEF_W-1:0]   op_a;
	logic signed [MOPB_W-1:0]   op_b;
	logic signed [MOPB_W-1:0]   mix;
	logic signed [PROD_W-1:0]   prod_d;
	logic signed [PROD_W-1:0]   rnd_a_sum;
	logic signed [PROD_W-1:0]   rnd_g_sum;
	logic signed [RND_A_W-1:0]  rnd_a;
	logic signed [RND_G_W-1:0]  rnd_g;
	logic signed [ACC_W-1:0]    xh_acc;
	logic signed [ACC_W-1:0]    y1_acc;
	logic signed [OUT_ACC_W-1:0] out_acc;

	// low shelf adds the allpass output, high shelf subtracts it
	assign mix = shelf_type_q ? (MOPB_W'(x_q) - MOPB_W'(y1_q))
	                          : (MOPB_W'(x_q) + MOPB_W'(y1_q));

	always_comb begin
		op_a = (cmd.mul_sel == MSEL_S) ? half_gain_q : coef_a_q;
		unique case (cmd.mul_sel)
			MSEL_W:  op_b = MOPB_W'(chan_state_q[channel_in]);
			MSEL_XH: op_b = MOPB_W'(xh_q);
			MSEL_S:  op_b = mix;
			default: op_b = '0;
		endcase
	end

	assign prod_d    = PROD_W'(op_a) * PROD_W'(op_b);
	assign rnd_a_sum = prod_q + HALF_A;
	assign rnd_g_sum = prod_q + HALF_G;
	assign rnd_a     = rnd_a_sum[PROD_W-1:COEF_FRAC];
	assign rnd_g     = rnd_g_sum[PROD_W-1:GAIN_FRAC];
	assign xh_acc    = ACC_W'(x_q) - ACC_W'(rnd_a);
	assign y1_acc    = ACC_W'(rnd_a) + ACC_W'(w_q);
	assign out_acc   = OUT_ACC_W'(x_q) + OUT_ACC_W'(rnd_g);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q     <= '0;
			half_gain_q  <= '0;
			shelf_type_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++)
				chan_state_q[i] <= '0;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					REG_COEF_A:     coef_a_q     <= wr_data;
					REG_HALF_GAIN:  half_gain_q  <= wr_data;
					REG_SHELF_TYPE: shelf_type_q <= wr_data[0];
					default: ;
				endcase
			end
			if (cmd.load_xh)
				chan_state_q[ch_q] <= sat_state(xh_acc);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x_q  <= sample_in;
			ch_q <= channel_in;
			w_q  <= chan_state_q[channel_in];
		end
		if (cmd.mul_en)
			prod_q <= prod_d;
		if (cmd.load_xh)
			xh_q <= sat_state(xh_acc);
		if (cmd.load_y1)
			y1_q <= sat_state(y1_acc);
		if (cmd.load_out) begin
			sample_out_q  <= sat_sample(out_acc);
			channel_out_q <= ch_q;
		end
	end

	assign sample_out  = sample_out_q;
	assign channel_out = channel_out_q;

endmodule

FILE: rtl/first_order_shelving_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_order_shelving_filter
// Stereo first-order shelving filter on an allpass section.
//
// Input channel: in_valid / in_stall with sample_in (signed Q1.23) and
// channel_in (0 left, 1 right). A word is taken when in_valid is high and
// in_stall is low. Output channel: out_valid / out_stall with sample_out
// and channel_out, one result word for every input word, in order.
// A taken word then goes XH, P2, Y1, P3, YO; YO registers the result.
// A new word is taken only when the sequence is idle: the single shared
// multiplier runs the three dependent products a*w, a*xh and
// half_gain*(x +/- y1), each followed by a rounding/saturation step.
// The output register holds a finished word while out_stall is high; the
// next input word is still taken and runs up to its output step, where it
// waits until the output register is free.
// Reset clears the coefficients, the shelf type and both channel states.
// Registers are written through wr_en / wr_index / wr_data, by the user only
// while idle (unenforced): 0 coef_a, 1 half_gain, 2 shelf_type, rest ignored.
// ----------------------------------------------------------------------------
module first_order_shelving_filter
	import fosf_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	input  logic                       channel_in,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] sample_out,
	output logic                       channel_out,
	input  logic                       wr_en,
	input  logic [REG_IDX_W-1:0]       wr_index,
	input  logic [COEF_W-1:0]          wr_data
);

	cmd_t cmd;

	// sequencer: handshakes and step order
	fosf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// arithmetic, channel state and output word register
	fosf_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.sample_in   (sample_in),
		.channel_in  (channel_in),
		.sample_out  (sample_out),
		.channel_out (channel_out)
	);

endmodule
